// ===== rtl/avgbg_pkg.sv =====
// Shared constants, codes and types of the averaging background subtractor.
// No dependencies.
`timescale 1ns / 1ps
package avgbg_pkg;
    localparam int PIXELS_DEF     = 65536;
    localparam int COUNT_BITS_DEF = 16;
    localparam int IDX_W          = 16;
    localparam int SAMPLE_W       = 8;
    localparam int MODE_W         = 2;
    localparam int SCALE_W        = 4;
    localparam int MEAN_W         = 16;
    localparam int DIV_STEPS      = 16;
    localparam int BOUND_W        = 21;
    localparam int STAGES         = DIV_STEPS + 2;
    localparam int FIFO_DEPTH     = 32;
    localparam int CFG_ADDR_W     = 1;

    localparam logic [MODE_W-1:0] MODE_ACC      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_SCALE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_SCALE  = 1'd1;

    localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 4'd6;
    localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 4'd5;

    typedef logic signed [BOUND_W-1:0] bound_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_range;
        logic              seen;
    } avgbg_ctrl_t;
endpackage

// ===== rtl/avgbg_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module avgbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/avgbg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, Q8.8 saturating result.
// Depends on avgbg_pkg.
`timescale 1ns / 1ps
module avgbg_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                     aclk,
    input  logic [COUNT_BITS+avgbg_pkg::MEAN_W:0]    dividend,
    input  logic [COUNT_BITS-1:0]                    divisor,
    output logic [avgbg_pkg::MEAN_W-1:0]             quot
);
    import avgbg_pkg::*;

    logic [COUNT_BITS-1:0] r_reg   [0:DIV_STEPS];
    logic [MEAN_W-1:0]     lo_reg  [0:DIV_STEPS];
    logic [COUNT_BITS-1:0] dvs_reg [0:DIV_STEPS];
    logic [DIV_STEPS:0]    sat_reg;
    logic [DIV_STEPS:0]    zero_reg;
    logic [COUNT_BITS:0]   hi;

    assign hi = dividend[COUNT_BITS+MEAN_W:MEAN_W];

    always_ff @(posedge aclk) begin
        r_reg[0]    <= hi[COUNT_BITS-1:0];
        lo_reg[0]   <= dividend[MEAN_W-1:0];
        dvs_reg[0]  <= divisor;
        sat_reg[0]  <= hi >= {1'b0, divisor};
        zero_reg[0] <= divisor == '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [COUNT_BITS:0] t;
        logic [COUNT_BITS:0] d;
        assign t = {r_reg[k], lo_reg[k][MEAN_W-1]};
        assign d = t - {1'b0, dvs_reg[k]};
        always_ff @(posedge aclk) begin
            if (t >= {1'b0, dvs_reg[k]}) begin
                r_reg[k+1]  <= d[COUNT_BITS-1:0];
                lo_reg[k+1] <= {lo_reg[k][MEAN_W-2:0], 1'b1};
            end else begin
                r_reg[k+1]  <= t[COUNT_BITS-1:0];
                lo_reg[k+1] <= {lo_reg[k][MEAN_W-2:0], 1'b0};
            end
            dvs_reg[k+1]  <= dvs_reg[k];
            sat_reg[k+1]  <= sat_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end
    end

    assign quot = zero_reg[DIV_STEPS] ? '0 :
                  sat_reg[DIV_STEPS]  ? '1 : lo_reg[DIV_STEPS];
endmodule

// ===== rtl/avgbg_lane.sv =====
// One color channel: statistics update, mean division, bound build and range test.
// Depends on avgbg_pkg, avgbg_ram, avgbg_div.
`timescale 1ns / 1ps
module avgbg_lane #(
    parameter int PIXELS     = 65536,
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  avgbg_pkg::avgbg_ctrl_t         in_ctrl,
    input  logic [$clog2(PIXELS)-1:0]      in_addr,
    input  logic [COUNT_BITS-1:0]          in_count,
    input  logic [avgbg_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [avgbg_pkg::SCALE_W-1:0]  high_scale,
    input  logic [avgbg_pkg::SCALE_W-1:0]  low_scale,
    input  logic                           clear_en,
    input  logic [$clog2(PIXELS)-1:0]      clear_addr,
    output logic                           out_hit
);
    import avgbg_pkg::*;

    localparam int AW    = $clog2(PIXELS);
    localparam int SW    = SAMPLE_W + COUNT_BITS;
    localparam int DVD_W = COUNT_BITS + MEAN_W + 1;
    localparam int PW    = SCALE_W + MEAN_W + 1;
    localparam int WW    = BOUND_W + 2;

    function automatic bound_t sat_bound(input logic signed [WW-1:0] v);
        if (v[WW-1:BOUND_W-1] == '0 || v[WW-1:BOUND_W-1] == '1) begin
            return v[BOUND_W-1:0];
        end else if (v[WW-1]) begin
            return {1'b1, {(BOUND_W-1){1'b0}}};
        end else begin
            return {1'b0, {(BOUND_W-1){1'b1}}};
        end
    endfunction

    logic [STAGES:1]       vld_reg;
    avgbg_ctrl_t           ctrl_reg   [1:STAGES];
    logic [AW-1:0]         addr_reg   [1:STAGES];
    logic [SAMPLE_W-1:0]   sample_reg [1:STAGES];
    logic [COUNT_BITS-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[STAGES-1:1], in_accept};
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg[1]   <= in_ctrl;
        addr_reg[1]   <= in_addr;
        sample_reg[1] <= in_sample;
        count_reg     <= in_count;
        for (int k = 2; k <= STAGES; k++) begin
            ctrl_reg[k]   <= ctrl_reg[k-1];
            addr_reg[k]   <= addr_reg[k-1];
            sample_reg[k] <= sample_reg[k-1];
        end
    end

    // statistics stage
    logic [SAMPLE_W-1:0] prev_rd, cur_prev, adiff;
    logic [2*SW-1:0]     sum_rd, cur_sum, sum_next, sum_wdata;
    logic [SW-1:0]       cur_avg, cur_dif, avg_next, dif_next;
    logic [SW:0]         avg_t, dif_t;
    logic                acc_we, sum_we, hit1;
    logic [AW-1:0]       sum_waddr;
    logic                fwd_v_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [SAMPLE_W-1:0] fwd_prev_reg;
    logic [2*SW-1:0]     fwd_sum_reg;
    logic [DVD_W-1:0]    dvd_avg, dvd_dif;

    avgbg_ram #(.WIDTH(SAMPLE_W), .DEPTH(PIXELS)) u_prev_ram (
        .aclk(aclk), .wr_en(acc_we), .wr_addr(addr_reg[1]), .wr_data(sample_reg[1]),
        .rd_addr(in_addr), .rd_data(prev_rd)
    );

    avgbg_ram #(.WIDTH(2*SW), .DEPTH(PIXELS)) u_sum_ram (
        .aclk(aclk), .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(sum_wdata),
        .rd_addr(in_addr), .rd_data(sum_rd)
    );

    assign hit1     = fwd_v_reg && (fwd_addr_reg == addr_reg[1]);
    assign cur_prev = hit1 ? fwd_prev_reg : prev_rd;
    assign cur_sum  = hit1 ? fwd_sum_reg : sum_rd;
    assign cur_avg  = cur_sum[SW-1:0];
    assign cur_dif  = cur_sum[2*SW-1:SW];
    assign adiff    = (sample_reg[1] > cur_prev) ? sample_reg[1] - cur_prev
                                                 : cur_prev - sample_reg[1];
    assign avg_t    = {1'b0, cur_avg} + (SW+1)'(sample_reg[1]);
    assign dif_t    = {1'b0, cur_dif} + (SW+1)'(adiff);
    assign avg_next = avg_t[SW] ? '1 : avg_t[SW-1:0];
    assign dif_next = dif_t[SW] ? '1 : dif_t[SW-1:0];
    assign sum_next = ctrl_reg[1].seen ? {dif_next, avg_next} : cur_sum;

    assign acc_we    = vld_reg[1] && ctrl_reg[1].mode == MODE_ACC && ctrl_reg[1].in_range;
    assign sum_we    = acc_we || clear_en;
    assign sum_waddr = clear_en ? clear_addr : addr_reg[1];
    assign sum_wdata = clear_en ? '0 : sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg <= 1'b0;
        end else begin
            fwd_v_reg <= acc_we;
        end
        fwd_addr_reg <= addr_reg[1];
        fwd_prev_reg <= sample_reg[1];
        fwd_sum_reg  <= sum_next;
    end

    assign dvd_avg = DVD_W'({cur_avg, 8'h00}) + DVD_W'(count_reg >> 1);
    assign dvd_dif = DVD_W'({cur_dif, 8'h00}) + DVD_W'(count_reg >> 1);

    logic [MEAN_W-1:0] q_avg, q_dif;

    avgbg_div #(.COUNT_BITS(COUNT_BITS)) u_div_avg (
        .aclk(aclk), .dividend(dvd_avg), .divisor(count_reg), .quot(q_avg)
    );

    avgbg_div #(.COUNT_BITS(COUNT_BITS)) u_div_dif (
        .aclk(aclk), .dividend(dvd_dif), .divisor(count_reg), .quot(q_dif)
    );

    // bound stage
    logic [MEAN_W:0]          dif1;
    logic [PW-1:0]            prod_h, prod_l;
    logic signed [WW-1:0]     high_w, low_w;
    bound_t                   high_b, low_b, cur_high, cur_low, x;
    logic [2*BOUND_W-1:0]     bnd_rd;
    logic                     bnd_we, hitb;
    logic                     bfwd_v_reg;
    logic [AW-1:0]            bfwd_addr_reg;
    logic [2*BOUND_W-1:0]     bfwd_data_reg;
    logic                     hit_reg;

    assign dif1   = {1'b0, q_dif} + (MEAN_W+1)'(256);
    assign prod_h = PW'(high_scale) * PW'(dif1);
    assign prod_l = PW'(low_scale) * PW'(dif1);
    assign high_w = $signed(WW'(q_avg)) + $signed(WW'(prod_h));
    assign low_w  = $signed(WW'(q_avg)) - $signed(WW'(prod_l));
    assign high_b = sat_bound(high_w);
    assign low_b  = sat_bound(low_w);
    assign bnd_we = vld_reg[STAGES] && ctrl_reg[STAGES].mode == MODE_BUILD
                    && ctrl_reg[STAGES].in_range;

    avgbg_ram #(.WIDTH(2*BOUND_W), .DEPTH(PIXELS)) u_bound_ram (
        .aclk(aclk), .wr_en(bnd_we), .wr_addr(addr_reg[STAGES]), .wr_data({high_b, low_b}),
        .rd_addr(addr_reg[STAGES-1]), .rd_data(bnd_rd)
    );

    assign hitb     = bfwd_v_reg && (bfwd_addr_reg == addr_reg[STAGES]);
    assign cur_high = hitb ? bfwd_data_reg[2*BOUND_W-1:BOUND_W] : bnd_rd[2*BOUND_W-1:BOUND_W];
    assign cur_low  = hitb ? bfwd_data_reg[BOUND_W-1:0] : bnd_rd[BOUND_W-1:0];
    assign x        = {5'b0, sample_reg[STAGES], 8'h00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bfwd_v_reg <= 1'b0;
        end else begin
            bfwd_v_reg <= bnd_we;
        end
        bfwd_addr_reg <= addr_reg[STAGES];
        bfwd_data_reg <= {high_b, low_b};
        hit_reg       <= (x >= cur_low) && (x <= cur_high);
    end

    assign out_hit = hit_reg;
endmodule

// ===== rtl/average_background_subtractor_unit.sv =====
// Top level: three channel lanes, frame counters, result merge and output queue.
// Depends on avgbg_pkg, avgbg_lane.
//
//  channel | ports                  | contents
//  input   | s_tvalid/s_tready      | tdata: pixel_index, a, b, c; tlast: eof; tuser: mode
//  output  | m_tvalid/m_tready      | tdata: result_index, foreground
//  config  | cfg_wr_en/addr/wr_data | 0 high_scale, 1 low_scale
//
// One pixel per cycle while s_tready is high; each classify transaction yields one result.
// Each result passes the statistics stage, the 17-stage divider pipeline and the bound stage.
// After reset the statistics memory is cleared, one address at a time, with s_tready low.
// A 32-entry output queue with credit tracking absorbs m_tready stalls.
`timescale 1ns / 1ps
module average_background_subtractor_unit #(
    parameter int PIXELS     = avgbg_pkg::PIXELS_DEF,
    parameter int COUNT_BITS = avgbg_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,  // pixel_index, channel_a, b, c
    input  logic                             s_tlast,  // end_of_frame
    input  logic [avgbg_pkg::MODE_W-1:0]     s_tuser,  // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,  // result_index, foreground
    input  logic                             cfg_wr_en,
    input  logic [avgbg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [avgbg_pkg::SCALE_W-1:0]    cfg_wr_data
);
    import avgbg_pkg::*;

    localparam int AW      = $clog2(PIXELS);
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int RES_W   = IDX_W + 1;

    logic [SCALE_W-1:0]    high_scale_reg, low_scale_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  seen_reg;
    logic                  clearing_reg;
    logic [AW-1:0]         clear_addr_reg;
    logic                  accept, in_range;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W+AW-1:0]   idx_ext;
    logic [AW-1:0]         addr;
    avgbg_ctrl_t           ctrl;

    assign accept   = s_tvalid && s_tready;
    assign idx      = s_tdata[IDX_W-1:0];
    assign in_range = 32'(idx) < 32'(PIXELS);
    assign idx_ext  = (IDX_W+AW)'(idx);
    assign addr     = idx_ext[AW-1:0];
    assign ctrl     = '{mode: s_tuser, in_range: in_range, seen: seen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_scale_reg <= HIGH_SCALE_RST;
            low_scale_reg  <= LOW_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HIGH_SCALE: high_scale_reg <= cfg_wr_data;
                REG_LOW_SCALE:  low_scale_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (accept && s_tuser == MODE_ACC && s_tlast) begin
            if (seen_reg && count_reg != '1) begin
                count_reg <= count_reg + 1'b1;
            end
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clear_addr_reg == AW'(PIXELS - 1)) begin
                clearing_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    logic [2:0] hits;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        avgbg_lane #(.PIXELS(PIXELS), .COUNT_BITS(COUNT_BITS)) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_accept  (accept),
            .in_ctrl    (ctrl),
            .in_addr    (addr),
            .in_count   (count_reg),
            .in_sample  (s_tdata[IDX_W + g*SAMPLE_W +: SAMPLE_W]),
            .high_scale (high_scale_reg),
            .low_scale  (low_scale_reg),
            .clear_en   (clearing_reg),
            .clear_addr (clear_addr_reg),
            .out_hit    (hits[g])
        );
    end

    // result tag pipeline, aligned with the lanes
    logic [STAGES+1:1] rvld_reg;
    logic [IDX_W-1:0]  ridx_reg [1:STAGES+1];
    logic [STAGES+1:1] rin_reg;
    logic              push, pop, fg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvld_reg <= '0;
        end else begin
            rvld_reg <= {rvld_reg[STAGES:1], accept && s_tuser == MODE_CLASSIFY};
        end
        rin_reg     <= {rin_reg[STAGES:1], in_range};
        ridx_reg[1] <= idx;
        for (int k = 2; k <= STAGES + 1; k++) begin
            ridx_reg[k] <= ridx_reg[k-1];
        end
    end

    assign push = rvld_reg[STAGES+1];
    assign fg   = rin_reg[STAGES+1] && !(|hits);

    // output queue
    logic [RES_W-1:0]   fifo_mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [FIFO_AW:0]   credit_reg, credit_next;
    logic               take_cls;

    assign pop      = m_tvalid && m_tready;
    assign take_cls = accept && s_tuser == MODE_CLASSIFY;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        credit_next   = credit_reg;
        if (push) fifo_cnt_next = fifo_cnt_next + 1'b1;
        if (pop) begin
            fifo_cnt_next = fifo_cnt_next - 1'b1;
            credit_next   = credit_next - 1'b1;
        end
        if (take_cls) credit_next = credit_next + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
        end
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= {fg, ridx_reg[STAGES+1]};
        end
    end

    assign s_tready = !clearing_reg && (credit_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = 24'(fifo_mem_reg[rd_ptr_reg]);

`ifndef ASSERT_OFF
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("credit count exceeds queue depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> fifo_cnt_reg < (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue overflow");
    a_cnt_le_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= credit_reg)
        else $error("queued results exceed reserved credits");
    a_no_take_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready)
        else $error("transaction taken during memory clear");
`endif
endmodule
